@@ rtl/brbs_pkg.sv @@
// Shared types, codes and sizes for the byte ring buffer with search.
package brbs_pkg;

    // Storage geometry
    localparam int DEPTH       = 256;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int SIZE_W      = 9;
    localparam int FILL_W      = 8;
    localparam int MAX_PATTERN = 8;
    localparam int MAX_READ    = 64;
    localparam int MIDX_W      = $clog2(MAX_PATTERN) > 0 ? $clog2(MAX_PATTERN) : 1;

    // Item kinds
    localparam logic [1:0] KIND_STORE  = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_FLUSH  = 2'd2;
    localparam logic [1:0] KIND_SEARCH = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ERR      = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SIZE    = 2'd0;
    localparam logic [1:0] CFG_PATTERN = 2'd1;
    localparam logic [1:0] CFG_PAT_LEN = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [6:0] count;
        logic       first;
    } t_item;

    typedef struct packed {
        logic [7:0]        read_byte;
        logic              last;
        logic [1:0]        status;
        logic [7:0]        position;
        logic [FILL_W-1:0] fill;
    } t_result;

    // Active settings handed to the sequencer
    typedef struct packed {
        logic [SIZE_W-1:0] size;     // clamped to 2..DEPTH
        logic [63:0]       pattern;
        logic [3:0]        pat_len;  // clamped to 1..MAX_PATTERN
        logic              size_wr;  // size register written this cycle
    } t_cfg;

endpackage

@@ rtl/brbs_ram.sv @@
// Generic single-write, single-read memory with registered read data.
module brbs_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/brbs_match.sv @@
// Pattern compare step: checks one stored byte against the current match index.
module brbs_match (
    input  logic [7:0]                  i_byte,
    input  logic [brbs_pkg::MIDX_W-1:0] i_m,
    input  logic [63:0]                 i_pattern,
    input  logic [3:0]                  i_pat_len,
    output logic                        o_hit,
    output logic [brbs_pkg::MIDX_W-1:0] o_m_next
);
    import brbs_pkg::*;

    logic [7:0] w_pat_m;
    logic       w_eq;
    logic       w_eq0;
    logic [3:0] w_m_ext;

    // Select pattern byte at the match index
    assign w_pat_m = i_pattern[i_m*8 +: 8];
    assign w_eq    = (i_byte == w_pat_m);
    assign w_eq0   = (i_byte == i_pattern[7:0]);
    assign w_m_ext = 4'(i_m);

    assign o_hit    = w_eq && (w_m_ext == i_pat_len - 4'd1);
    // Advance on a match, restart at 0 or 1 on a mismatch
    assign o_m_next = w_eq ? MIDX_W'(i_m + 1'b1) : MIDX_W'(w_eq0);

endmodule

@@ rtl/brbs_core.sv @@
// Sequencer, ring pointers and storage of the byte ring buffer.
module brbs_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  brbs_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  brbs_pkg::t_item   i_item,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output brbs_pkg::t_result o_res
);
    import brbs_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EMIT     = 3'd1;
    localparam logic [2:0] S_RD_ISSUE = 3'd2;
    localparam logic [2:0] S_RD_EMIT  = 3'd3;
    localparam logic [2:0] S_SR_ISSUE = 3'd4;
    localparam logic [2:0] S_SR_CMP   = 3'd5;

    logic [2:0]        r_state,     n_state;
    logic [PTR_W-1:0]  r_wr_pos,    n_wr_pos;
    logic [PTR_W-1:0]  r_rd_pos,    n_rd_pos;
    logic              r_rejected,  n_rejected;
    logic [6:0]        r_remain,    n_remain;
    logic [FILL_W-1:0] r_fin_fill,  n_fin_fill;
    logic [1:0]        r_status,    n_status;
    logic [7:0]        r_position,  n_position;
    logic [MIDX_W-1:0] r_m,         n_m;
    logic [7:0]        r_idx,       n_idx;
    logic [PTR_W-1:0]  r_scan_pos,  n_scan_pos;
    logic [FILL_W-1:0] r_scan_fill, n_scan_fill;

    logic              w_we;
    logic              w_re;
    logic [PTR_W-1:0]  w_raddr;
    logic [7:0]        w_rdata;
    logic              w_hit;
    logic [MIDX_W-1:0] w_m_next;
    logic [SIZE_W-1:0] w_fill_ext;
    logic [FILL_W-1:0] w_fill;
    logic [SIZE_W-1:0] w_cap;
    logic [6:0]        w_burst;
    logic              w_burst_rej;
    logic              w_store_ok;
    logic              w_read_err;
    logic [7:0]        w_idx_inc;

    // Advance a ring position, wrapping at the active size
    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p,
                                                  input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] inc;
        inc = SIZE_W'(p) + SIZE_W'(1);
        return (inc == s) ? '0 : PTR_W'(inc);
    endfunction

    brbs_ram #(
        .DATA_W (8),
        .ADDR_W (PTR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wr_pos),
        .i_wdata (i_item.data),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    brbs_match u_match (
        .i_byte    (w_rdata),
        .i_m       (r_m),
        .i_pattern (i_cfg.pattern),
        .i_pat_len (i_cfg.pat_len),
        .o_hit     (w_hit),
        .o_m_next  (w_m_next)
    );

    // Fill from the pointers
    assign w_fill_ext = SIZE_W'(r_wr_pos) - SIZE_W'(r_rd_pos)
                        + ((r_wr_pos < r_rd_pos) ? i_cfg.size : '0);
    assign w_fill     = FILL_W'(w_fill_ext);
    assign w_cap      = i_cfg.size - SIZE_W'(1);

    // Store and read admission checks
    assign w_burst     = (i_item.count == '0) ? 7'd1 : i_item.count;
    assign w_burst_rej = (SIZE_W'(w_fill) + SIZE_W'(w_burst)) > w_cap;
    assign w_store_ok  = i_item.first ? !w_burst_rej
                                      : (!r_rejected && (SIZE_W'(w_fill) < w_cap));
    assign w_read_err  = (i_item.count == '0) || (i_item.count > 7'(MAX_READ))
                         || (SIZE_W'(i_item.count) > SIZE_W'(w_fill));
    assign w_idx_inc   = r_idx + 8'd1;

    assign o_ready = (r_state == S_IDLE);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_wr_pos    = r_wr_pos;
        n_rd_pos    = r_rd_pos;
        n_rejected  = r_rejected;
        n_remain    = r_remain;
        n_fin_fill  = r_fin_fill;
        n_status    = r_status;
        n_position  = r_position;
        n_m         = r_m;
        n_idx       = r_idx;
        n_scan_pos  = r_scan_pos;
        n_scan_fill = r_scan_fill;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_raddr     = r_rd_pos;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_position = '0;
                    case (i_item.kind)
                        KIND_STORE: begin
                            if (i_item.first) begin
                                n_rejected = w_burst_rej;
                            end
                            if (w_store_ok) begin
                                w_we     = 1'b1;
                                n_wr_pos = next_pos(r_wr_pos, i_cfg.size);
                            end
                            n_status = w_store_ok ? ST_OK : ST_ERR;
                            n_state  = S_EMIT;
                        end
                        KIND_READ: begin
                            if (w_read_err) begin
                                n_status = ST_ERR;
                                n_state  = S_EMIT;
                            end else begin
                                n_remain   = i_item.count;
                                n_fin_fill = w_fill - FILL_W'(i_item.count);
                                n_state    = S_RD_ISSUE;
                            end
                        end
                        KIND_FLUSH: begin
                            n_wr_pos = '0;
                            n_rd_pos = '0;
                            n_status = ST_OK;
                            n_state  = S_EMIT;
                        end
                        default: begin
                            if (w_fill == '0) begin
                                n_status = ST_NOTFOUND;
                                n_state  = S_EMIT;
                            end else begin
                                n_scan_pos  = r_rd_pos;
                                n_scan_fill = w_fill;
                                n_m         = '0;
                                n_idx       = '0;
                                n_state     = S_SR_ISSUE;
                            end
                        end
                    endcase
                end
            end
            S_EMIT: begin
                o_res_valid     = 1'b1;
                o_res.last      = 1'b1;
                o_res.status    = r_status;
                o_res.position  = r_position;
                o_res.fill      = w_fill;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_RD_ISSUE: begin
                w_re    = 1'b1;
                w_raddr = r_rd_pos;
                n_state = S_RD_EMIT;
            end
            S_RD_EMIT: begin
                o_res_valid     = 1'b1;
                o_res.read_byte = w_rdata;
                o_res.last      = (r_remain == 7'd1);
                o_res.status    = ST_OK;
                o_res.fill      = r_fin_fill;
                if (i_res_ready) begin
                    n_rd_pos = next_pos(r_rd_pos, i_cfg.size);
                    n_remain = r_remain - 7'd1;
                    n_state  = (r_remain == 7'd1) ? S_IDLE : S_RD_ISSUE;
                end
            end
            S_SR_ISSUE: begin
                w_re    = 1'b1;
                w_raddr = r_scan_pos;
                n_state = S_SR_CMP;
            end
            S_SR_CMP: begin
                if (w_hit) begin
                    n_status   = ST_OK;
                    n_position = w_idx_inc;
                    n_state    = S_EMIT;
                end else begin
                    n_m        = w_m_next;
                    n_scan_pos = next_pos(r_scan_pos, i_cfg.size);
                    n_idx      = w_idx_inc;
                    if (w_idx_inc == 8'(r_scan_fill)) begin
                        n_status = ST_NOTFOUND;
                        n_state  = S_EMIT;
                    end else begin
                        n_state = S_SR_ISSUE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Size change empties the buffer
        if (i_cfg.size_wr) begin
            n_wr_pos   = '0;
            n_rd_pos   = '0;
            n_rejected = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wr_pos   <= '0;
            r_rd_pos   <= '0;
            r_rejected <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wr_pos   <= n_wr_pos;
            r_rd_pos   <= n_rd_pos;
            r_rejected <= n_rejected;
        end
    end

    // Work registers
    always_ff @(posedge i_clk) begin
        r_remain    <= n_remain;
        r_fin_fill  <= n_fin_fill;
        r_status    <= n_status;
        r_position  <= n_position;
        r_m         <= n_m;
        r_idx       <= n_idx;
        r_scan_pos  <= n_scan_pos;
        r_scan_fill <= n_scan_fill;
    end

endmodule

@@ rtl/byte_ring_buffer_with_search_top.sv @@
// Top level of the byte ring buffer with search: registers, core and output stage.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------------
//  s stream | in        | i_s_tvalid / o_s_tready    | tdata {count, data}, tuser {first, kind}
//  m stream | out       | o_m_tvalid / i_m_tready    | tdata {fill, position, read_byte},
//           |           |                            | tuser status, tlast last
//  cfg      | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  Store, flush and failed reads give one result, held in the EMIT state until the output register takes it.
//  A read of N bytes gives N beats: one memory read port is read once per byte, each byte sent before the next read.
//  A search reads the stored bytes oldest first, one at a time, through the compare step,
//  up to the first hit or the fill. No beat is accepted until the previous item has left the core.
//  Reset is synchronous; it empties the buffer and sets size 256, pattern 0, length 1.
//  The output register lets the core hand off its last result while the sink stalls.
module byte_ring_buffer_with_search_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] data, [14:8] count, [15] zero
    input  logic [2:0]  i_s_tuser,   // [1:0] kind, [2] first
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] read_byte, [15:8] position, [23:16] fill
    output logic [1:0]  o_m_tuser,   // [1:0] status
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import brbs_pkg::*;

    logic [SIZE_W-1:0] r_size;
    logic [63:0]       r_pattern;
    logic [3:0]        r_pat_len;
    logic              r_out_valid;
    t_result           r_out;

    t_cfg              w_cfg;
    t_item             w_item;
    t_result           w_res;
    logic              w_res_valid;
    logic              w_slot_free;
    logic              w_cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= SIZE_W'(DEPTH);
            r_pattern <= '0;
            r_pat_len <= 4'd1;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_SIZE:    r_size    <= i_cfg_data[SIZE_W-1:0];
                CFG_PATTERN: r_pattern <= i_cfg_data;
                CFG_PAT_LEN: r_pat_len <= i_cfg_data[3:0];
                default:     ;
            endcase
        end
    end

    // Clamp settings to their working ranges
    always_comb begin
        w_cfg.pattern = r_pattern;
        w_cfg.size_wr = w_cfg_wr && (i_cfg_index == CFG_SIZE);
        if (r_size < SIZE_W'(2)) begin
            w_cfg.size = SIZE_W'(2);
        end else if (r_size > SIZE_W'(DEPTH)) begin
            w_cfg.size = SIZE_W'(DEPTH);
        end else begin
            w_cfg.size = r_size;
        end
        if (r_pat_len == 4'd0) begin
            w_cfg.pat_len = 4'd1;
        end else if (r_pat_len > 4'(MAX_PATTERN)) begin
            w_cfg.pat_len = 4'(MAX_PATTERN);
        end else begin
            w_cfg.pat_len = r_pat_len;
        end
    end

    // Unpack the input beat
    assign w_item.kind  = i_s_tuser[1:0];
    assign w_item.first = i_s_tuser[2];
    assign w_item.data  = i_s_tdata[7:0];
    assign w_item.count = i_s_tdata[14:8];

    brbs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_slot_free),
        .o_res       (w_res)
    );

    // Output register: load when empty or being drained
    assign w_slot_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_slot_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.fill, r_out.position, r_out.read_byte};
    assign o_m_tuser  = r_out.status;
    assign o_m_tlast  = r_out.last;

endmodule

@@ sim/byte_ring_buffer_with_search_top_test.sv @@
// Self-checking testbench for the byte ring buffer with search, driven over its stream ports.
`timescale 1ns / 100ps

module byte_ring_buffer_with_search_top_test;

    import brbs_pkg::*;

    localparam int unsigned LONG_GAP      = 40;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned TAIL_CYCLES   = 24;
    localparam int unsigned ITEM_CAP      = 600;
    // worst case per item: a full-length read with every result stalled, or a full search
    localparam int unsigned CYCLE_LIMIT   =
        ITEM_CAP * (MAX_READ * (LONG_GAP + 3) + 2 * DEPTH + LONG_GAP + 8) * 3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;   // [7:0] data, [14:8] count, [15] zero
    logic [2:0]  i_s_tuser;   // [1:0] kind, [2] first
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;   // [7:0] read_byte, [15:8] position, [23:16] fill
    logic [1:0]  o_m_tuser;   // [1:0] status
    logic        o_m_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    // Mirror of the ring: storage, pointers, settings and the results still owed
    class ring_scoreboard;
        logic [7:0]  mem [DEPTH];
        int unsigned wr_pos;
        int unsigned rd_pos;
        bit          drop_burst;
        logic [8:0]  size_reg;
        logic [63:0] pat_reg;
        logic [3:0]  pat_len_reg;
        t_result     pending [$];
        int unsigned errors;

        function new();
            wr_pos      = 0;
            rd_pos      = 0;
            drop_burst  = 1'b0;
            size_reg    = 9'd256;
            pat_reg     = '0;
            pat_len_reg = 4'd1;
            errors      = 0;
            foreach (mem[i]) mem[i] = 8'h00;
        endfunction

        // Clamp the size register to 2..DEPTH
        function int unsigned live_size();
            if (size_reg < 2) return 2;
            if (size_reg > DEPTH) return DEPTH;
            return size_reg;
        endfunction

        // Clamp the pattern length register to 1..MAX_PATTERN
        function int unsigned live_pat_len();
            if (pat_len_reg < 1) return 1;
            if (pat_len_reg > MAX_PATTERN) return MAX_PATTERN;
            return pat_len_reg;
        endfunction

        function int unsigned fill_level();
            return (wr_pos >= rd_pos) ? wr_pos - rd_pos : wr_pos + live_size() - rd_pos;
        endfunction

        function logic [7:0] pat_byte(int unsigned i);
            return pat_reg[(i % 8) * 8 +: 8];
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] value);
            case (idx)
                CFG_SIZE: begin
                    size_reg   = value[8:0];
                    wr_pos     = 0;
                    rd_pos     = 0;
                    drop_burst = 1'b0;
                end
                CFG_PATTERN: pat_reg = value;
                CFG_PAT_LEN: pat_len_reg = value[3:0];
                default: ;
            endcase
        endfunction

        // Queue one expected beat; fill is taken as it stands now
        function void queue_result(logic [7:0] rbyte, logic last, logic [1:0] status,
                                   logic [7:0] pos);
            t_result r;
            r.read_byte = rbyte;
            r.last      = last;
            r.status    = status;
            r.position  = pos;
            r.fill      = fill_level();
            pending.push_back(r);
        endfunction

        // Work out every result beat caused by one accepted input beat
        function void note_item(t_item it);
            int unsigned cap, n, len, f, p, m, pos, i;
            bit          ok, hit;
            logic [7:0]  b;
            logic [7:0]  taken [$];
            cap = live_size() - 1;
            case (it.kind)
                KIND_STORE: begin
                    if (it.first) begin
                        n          = (it.count == 0) ? 1 : it.count;
                        drop_burst = (fill_level() + n > cap);
                        ok         = !drop_burst;
                    end else begin
                        ok = !drop_burst && (fill_level() < cap);
                    end
                    if (ok) begin
                        mem[wr_pos] = it.data;
                        wr_pos      = (wr_pos + 1) % live_size();
                    end
                    queue_result(8'h00, 1'b1, ok ? ST_OK : ST_ERR, 8'h00);
                end
                KIND_READ: begin
                    n = it.count;
                    if (n == 0 || n > MAX_READ || n > fill_level()) begin
                        queue_result(8'h00, 1'b1, ST_ERR, 8'h00);
                    end else begin
                        // remove all bytes first: every beat reports the final fill
                        for (i = 0; i < n; i++) begin
                            taken.push_back(mem[rd_pos]);
                            rd_pos = (rd_pos + 1) % live_size();
                        end
                        for (i = 0; i < n; i++)
                            queue_result(taken[i], i == n - 1, ST_OK, 8'h00);
                    end
                end
                KIND_FLUSH: begin
                    wr_pos = 0;
                    rd_pos = 0;
                    queue_result(8'h00, 1'b1, ST_OK, 8'h00);
                end
                default: begin
                    // walk the stored bytes oldest first; on a miss restart at 0 or 1
                    len = live_pat_len();
                    f   = fill_level();
                    p   = rd_pos;
                    m   = 0;
                    hit = 1'b0;
                    pos = 0;
                    for (i = 0; i < f && !hit; i++) begin
                        b = mem[p];
                        if (b == pat_byte(m)) begin
                            if (m == len - 1) begin
                                hit = 1'b1;
                                pos = i + 1;
                            end else begin
                                m++;
                            end
                        end else begin
                            m = (b == pat_byte(0)) ? 1 : 0;
                        end
                        p = (p + 1) % live_size();
                    end
                    if (hit) queue_result(8'h00, 1'b1, ST_OK, 8'(pos));
                    else queue_result(8'h00, 1'b1, ST_NOTFOUND, 8'h00);
                end
            endcase
        endfunction

        task report(string what, int unsigned want, int unsigned got);
            errors++;
            $display("[%0t] MISMATCH %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        endtask

        // Compare one output beat against the oldest expectation
        task check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                report("result beat with none outstanding", 0, got);
                return;
            end
            want = pending.pop_front();
            if (got.read_byte !== want.read_byte) report("read_byte", want.read_byte, got.read_byte);
            if (got.last !== want.last) report("last", want.last, got.last);
            if (got.status !== want.status) report("status", want.status, got.status);
            if (got.position !== want.position) report("position", want.position, got.position);
            if (got.fill !== want.fill) report("fill", want.fill, got.fill);
        endtask
    endclass

    ring_scoreboard sb;
    bit             calm;
    int unsigned    beats_sent;
    int unsigned    cycles;
    int unsigned    sink_stall;

    byte_ring_buffer_with_search_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, LONG_GAP);
    endfunction

    function automatic t_item mk(logic [1:0] kind, logic [7:0] data, logic [6:0] count,
                                 logic first);
        t_item it;
        it.kind  = kind;
        it.data  = data;
        it.count = count;
        it.first = first;
        return it;
    endfunction

    // Pattern built mostly from two bytes so partial matches and restarts occur
    function automatic logic [63:0] rand_pattern();
        logic [63:0] v;
        int unsigned i, r;
        for (i = 0; i < 8; i++) begin
            r = $urandom_range(0, 2);
            v[i * 8 +: 8] = (r == 0) ? 8'h5A : (r == 1) ? 8'hA5 : 8'($urandom_range(0, 255));
        end
        return v;
    endfunction

    // Sink: stall at random, change ready at the falling edge
    initial begin
        i_m_tready = 1'b0;
        sink_stall = 0;
        forever begin
            @(negedge i_clk);
            if (sink_stall > 0) begin
                i_m_tready = 1'b0;
                sink_stall--;
            end else begin
                i_m_tready = 1'b1;
                sink_stall = calm ? 0 : pick_gap();
            end
        end
    end

    // Check every output beat taken at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(t_result'({o_m_tdata[7:0], o_m_tlast, o_m_tuser,
                                       o_m_tdata[15:8], o_m_tdata[23:16]}));
    end

    // Offer one input beat after a random gap and hold it until taken
    task automatic push_beat(t_item it);
        int unsigned gap;
        gap = calm ? 0 : pick_gap();
        @(negedge i_clk);
        repeat (gap) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {1'b0, it.count, it.data};
        i_s_tuser  = {it.first, it.kind};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(it);
        beats_sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Drop valid and wait until every owed beat has come out
    task automatic settle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic retune(logic [8:0] size, logic [63:0] pattern, logic [3:0] pat_len);
        settle();
        write_reg(CFG_SIZE, {55'd0, size});
        write_reg(CFG_PATTERN, pattern);
        write_reg(CFG_PAT_LEN, {60'd0, pat_len});
    endtask

    // Random traffic: mostly well-formed bursts, reads and searches, some noise
    task automatic run_random(int unsigned budget);
        int unsigned stop, op, n, burst_n, k, len, f, j;
        logic [7:0]  d;
        stop = beats_sent + budget;
        while (beats_sent < stop) begin
            op  = $urandom_range(0, 99);
            f   = sb.fill_level();
            len = sb.live_pat_len();
            if (op < 45) begin
                // burst of pattern-like bytes; sometimes oversized, short or long
                if ($urandom_range(0, 9) < 8) n = $urandom_range(1, 8);
                else n = $urandom_range(0, 127);
                burst_n = (n == 0) ? 1 : n;
                if (burst_n > 16) burst_n = $urandom_range(1, 16);
                else if ($urandom_range(0, 9) == 0) burst_n = $urandom_range(1, burst_n + 2);
                k = $urandom_range(0, len - 1);
                for (j = 0; j < burst_n; j++) begin
                    if ($urandom_range(0, 6) == 0) d = 8'($urandom_range(0, 255));
                    else d = sb.pat_byte((k + j) % len);
                    push_beat(mk(KIND_STORE, d, (j == 0) ? 7'(n) : 7'($urandom_range(0, 127)),
                                 j == 0));
                end
            end else if (op < 65) begin
                if (f > 0 && $urandom_range(0, 4) != 0)
                    n = $urandom_range(1, (f < MAX_READ) ? f : MAX_READ);
                else
                    n = $urandom_range(0, 127);
                push_beat(mk(KIND_READ, 8'($urandom_range(0, 255)), 7'(n),
                             1'($urandom_range(0, 1))));
            end else if (op < 80) begin
                push_beat(mk(KIND_SEARCH, 8'($urandom_range(0, 255)),
                             7'($urandom_range(0, 127)), 1'($urandom_range(0, 1))));
            end else if (op < 85) begin
                push_beat(mk(KIND_FLUSH, 8'($urandom_range(0, 255)),
                             7'($urandom_range(0, 127)), 1'($urandom_range(0, 1))));
            end else begin
                push_beat(mk(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             7'($urandom_range(0, 127)), 1'($urandom_range(0, 1))));
            end
        end
    endtask

    // Main sequence
    initial begin
        sb          = new();
        calm        = 1'b0;
        beats_sent  = 0;
        cycles      = 0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: empty cases, zero burst length, bad read lengths
        push_beat(mk(KIND_SEARCH, 8'h00, 7'd0, 1'b0));
        push_beat(mk(KIND_READ, 8'h00, 7'd1, 1'b0));
        push_beat(mk(KIND_STORE, 8'h00, 7'd0, 1'b1));
        push_beat(mk(KIND_SEARCH, 8'hFF, 7'd127, 1'b1));
        push_beat(mk(KIND_STORE, 8'hFF, 7'd2, 1'b1));
        push_beat(mk(KIND_STORE, 8'hFF, 7'd127, 1'b0));
        push_beat(mk(KIND_READ, 8'hFF, 7'd0, 1'b1));
        push_beat(mk(KIND_READ, 8'h00, 7'd65, 1'b0));
        push_beat(mk(KIND_READ, 8'h00, 7'd127, 1'b0));
        push_beat(mk(KIND_READ, 8'h00, 7'd4, 1'b0));
        push_beat(mk(KIND_READ, 8'h00, 7'd3, 1'b0));
        push_beat(mk(KIND_FLUSH, 8'hFF, 7'd127, 1'b1));

        // Tiny ring: fill to capacity, restart on a miss, rejected bursts, wrap
        retune(9'd4, 64'h0000_0000_0000_A55A, 4'd2);
        push_beat(mk(KIND_STORE, 8'h5A, 7'd3, 1'b1));
        push_beat(mk(KIND_STORE, 8'h5A, 7'd0, 1'b0));
        push_beat(mk(KIND_STORE, 8'hA5, 7'd0, 1'b0));
        push_beat(mk(KIND_SEARCH, 8'h00, 7'd0, 1'b0));
        push_beat(mk(KIND_STORE, 8'h11, 7'd0, 1'b0));
        push_beat(mk(KIND_STORE, 8'h22, 7'd1, 1'b1));
        push_beat(mk(KIND_STORE, 8'h33, 7'd0, 1'b0));
        push_beat(mk(KIND_READ, 8'h00, 7'd2, 1'b0));
        push_beat(mk(KIND_STORE, 8'h44, 7'd0, 1'b0));
        push_beat(mk(KIND_STORE, 8'h5A, 7'd2, 1'b1));
        push_beat(mk(KIND_STORE, 8'hA5, 7'd0, 1'b0));
        push_beat(mk(KIND_SEARCH, 8'h00, 7'd0, 1'b0));
        push_beat(mk(KIND_STORE, 8'h66, 7'd127, 1'b1));

        // Random phases across sizes and pattern settings, extremes included
        retune(9'd2, {$urandom, $urandom}, 4'd1);
        run_random(16);
        retune(9'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
        run_random(16);
        calm = 1'b1;
        retune(9'd5, rand_pattern(), 4'd3);
        run_random(16);
        calm = 1'b0;
        retune(9'd511, rand_pattern(), 4'd8);
        run_random(16);
        retune(9'd256, rand_pattern(), 4'd15);
        run_random(16);
        calm = 1'b1;
        retune(9'($urandom_range(2, 40)), rand_pattern(), 4'($urandom_range(1, 4)));
        run_random(16);
        calm = 1'b0;
        retune(9'd17, 64'd0, 4'd2);
        run_random(16);

        // Drain, then let the pipeline go quiet
        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/brbs_pkg.sv
rtl/brbs_ram.sv
rtl/brbs_match.sv
rtl/brbs_core.sv
rtl/byte_ring_buffer_with_search_top.sv
sim/byte_ring_buffer_with_search_top_test.sv
